// ----- rtl/wgm_pkg.sv -----
`timescale 1ns / 1ps
package wgm_pkg;

  localparam int MAX_PATTERN = 32;

  localparam logic [7:0] STAR_BYTE = 8'h2A;
  localparam logic [7:0] ANY_BYTE  = 8'h3F;

  localparam logic [1:0] ACT_PATTERN = 2'd0;
  localparam logic [1:0] ACT_KEY     = 2'd1;
  localparam logic [1:0] ACT_END     = 2'd2;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] symbol;
    logic       restart;
  } in_t;

  typedef struct packed {
    logic matched;
    logic pattern_too_long;
  } out_t;

  // broadcast from the top level to every cell
  typedef struct packed {
    logic       wr_pattern;  // store symbol at the write position
    logic       key_step;    // advance the active bits by one key byte
    logic       rearm;       // reload active bits from the rearm vector
    logic [7:0] sym;
    logic       sym_star;
  } ctl_t;

  // handed from cell i to cell i+1
  typedef struct packed {
    logic step;   // transition from position i into i+1
    logic close;  // star closure into i+1
    logic rearm;  // rearm bit of position i
  } link_t;

endpackage

// ----- rtl/wildcard_glob_matcher.sv -----
`timescale 1ns / 1ps
// Anchored glob matcher: a pattern is loaded one byte per request (restart
// clears the old one first), then key bytes stream in and an end-of-key
// request returns one result saying whether the whole key matched the whole
// pattern; '*' matches any run of bytes, '?' any single byte. A new request
// is taken every cycle while in_stall is low: the matcher is a chain
// of MAX_PATTERN+1 cells, one per pattern position, each holding its pattern
// byte, its active bit and its rearm bit, and the active bits advance for
// all positions at once; the longest path is the star-closure ripple along
// the chain. Results leave through an output register backed by a one-entry
// skid register, so in_stall rises only when both are full. Pattern bytes
// past MAX_PATTERN are dropped and flag pattern_too_long, and every match
// then fails until a restart.
module wildcard_glob_matcher #(
  parameter int MAX_PATTERN = wgm_pkg::MAX_PATTERN
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  wgm_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output wgm_pkg::out_t out_data
);

  localparam int LW = $clog2(MAX_PATTERN + 1);

  // pattern bookkeeping
  logic [LW-1:0] len_r, len_nxt;
  logic          ovf_r, ovf_nxt;
  logic [LW-1:0] base;       // write position after an optional restart
  logic          can_wr;

  // output register and skid
  logic          out_v_r, out_v_nxt;
  wgm_pkg::out_t out_r, out_nxt;
  logic          skid_v_r, skid_v_nxt;
  wgm_pkg::out_t skid_r, skid_nxt;

  logic          in_acc, is_pat, is_key, is_end;
  wgm_pkg::ctl_t ctl;
  wgm_pkg::out_t res;

  wgm_pkg::link_t           link [0:MAX_PATTERN+1];
  logic [MAX_PATTERN:0]     act_vec;

  assign in_acc = in_valid & ~in_stall;
  assign is_pat = in_acc && (in_data.action == wgm_pkg::ACT_PATTERN);
  assign is_key = in_acc && (in_data.action == wgm_pkg::ACT_KEY);
  assign is_end = in_acc && (in_data.action == wgm_pkg::ACT_END);

  always_comb begin
    base   = in_data.restart ? '0 : len_r;
    can_wr = base < LW'(MAX_PATTERN);

    ctl.wr_pattern = is_pat & can_wr;
    ctl.key_step   = is_key;
    // any pattern byte (kept or dropped) and every key end rearm the vector
    ctl.rearm      = is_pat | is_end;
    ctl.sym        = in_data.symbol;
    ctl.sym_star   = in_data.symbol == wgm_pkg::STAR_BYTE;

    len_nxt = len_r;
    ovf_nxt = ovf_r;
    if (is_pat) begin
      if (can_wr) begin
        len_nxt = base + LW'(1);
      end
      ovf_nxt = in_data.restart ? 1'b0 : (ovf_r | ~can_wr);
    end

    // accept state is the bit at the pattern's end position
    res.matched          = act_vec[len_r] & ~ovf_r;
    res.pattern_too_long = ovf_r;
  end

  // position zero: nothing arrives from the left, rearm bit always set
  assign link[0] = '{step: 1'b0, close: 1'b0, rearm: 1'b1};

  for (genvar g = 0; g <= MAX_PATTERN; g++) begin : g_cell
    wgm_cell #(
      .MAX_PATTERN (MAX_PATTERN),
      .IDX         (g)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (ctl),
      .wr_pos   (base),
      .len      (len_r),
      .link_in  (link[g]),
      .link_out (link[g+1]),
      .active   (act_vec[g])
    );
  end

  // output register refills from the skid first, else from a new result
  always_comb begin
    out_v_nxt  = out_v_r;
    out_nxt    = out_r;
    skid_v_nxt = skid_v_r;
    skid_nxt   = skid_r;
    if (!out_v_r || !out_stall) begin
      if (skid_v_r) begin
        out_v_nxt  = 1'b1;
        out_nxt    = skid_r;
        skid_v_nxt = 1'b0;
      end else begin
        out_v_nxt = is_end;
        out_nxt   = res;
      end
    end else if (is_end) begin
      skid_v_nxt = 1'b1;
      skid_nxt   = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r    <= '0;
      ovf_r    <= 1'b0;
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      len_r    <= len_nxt;
      ovf_r    <= ovf_nxt;
      out_v_r  <= out_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

  assign in_stall  = skid_v_r;
  assign out_valid = out_v_r;
  assign out_data  = out_r;

endmodule

// ----- rtl/wgm_cell.sv -----
`timescale 1ns / 1ps
module wgm_cell #(
  parameter int MAX_PATTERN = wgm_pkg::MAX_PATTERN,
  parameter int IDX = 0
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  wgm_pkg::ctl_t                        ctl,
  input  logic [$clog2(MAX_PATTERN+1)-1:0]     wr_pos,
  input  logic [$clog2(MAX_PATTERN+1)-1:0]     len,
  input  wgm_pkg::link_t                       link_in,
  output wgm_pkg::link_t                       link_out,
  output logic                                 active
);

  localparam int LW = $clog2(MAX_PATTERN + 1);
  localparam logic [LW-1:0] POS     = LW'(IDX);
  localparam logic [LW:0]   POS_EXT = (LW + 1)'(IDX);

  logic [7:0] sym_r;
  logic       act_r, act_nxt;
  logic       rearm_r, rearm_nxt;
  logic       used, is_star, hit, closed;

  always_comb begin
    used    = POS < len;
    is_star = sym_r == wgm_pkg::STAR_BYTE;
    hit     = (sym_r == wgm_pkg::ANY_BYTE) || (sym_r == ctl.sym);
    // star self-loop plus whatever the left neighbour hands over
    closed  = (act_r & used & is_star) | link_in.step | link_in.close;

    link_out.step  = act_r & used & ~is_star & hit;
    link_out.close = closed & used & is_star;
    link_out.rearm = rearm_r;

    // a new byte one to the left extends the leading run of stars
    rearm_nxt = rearm_r;
    if (ctl.wr_pattern && (({1'b0, wr_pos} + (LW + 1)'(1)) == POS_EXT)) begin
      rearm_nxt = link_in.rearm & ctl.sym_star;
    end

    if (ctl.rearm) begin
      act_nxt = rearm_nxt;
    end else if (ctl.key_step) begin
      act_nxt = closed;
    end else begin
      act_nxt = act_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r   <= (IDX == 0);
      rearm_r <= (IDX == 0);
    end else begin
      act_r   <= act_nxt;
      rearm_r <= rearm_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.wr_pattern && (wr_pos == POS)) begin
      sym_r <= ctl.sym;
    end
  end

  assign active = act_r;

endmodule

// ----- rtl/wgm_checker.sv -----
`timescale 1ns / 1ps
module wgm_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          in_valid,
  input logic          in_stall,
  input wgm_pkg::in_t  in_data,
  input logic          out_valid,
  input logic          out_stall,
  input wgm_pkg::out_t out_data
);

  // held result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_data))
    else $error("stalled result changed");

  // a dropped pattern byte never lets a key match
  a_ovf_nomatch: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.pattern_too_long |-> !out_data.matched)
    else $error("match reported with overlong pattern");

  // input only backs up behind a stalled result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> $past(out_valid && out_stall))
    else $error("input stalled without output back-pressure");

  // key end into an empty output shows up next cycle
  a_end_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_data.action == wgm_pkg::ACT_END) && !out_valid
    |=> out_valid)
    else $error("key end gave no result");

endmodule

bind wildcard_glob_matcher wgm_checker u_wgm_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

// ----- tb/sv/tb_wildcard_glob_matcher.sv -----
`timescale 1ns / 1ps
// Glob matcher check: a short run of directed requests (empty pattern and
// key, stars only, '?', the zero byte and 0xFF, a pattern changed mid-key,
// restart on key requests, the unused action code, pattern overflow, a long
// result hold-off), then about 670 random requests built mostly as whole
// pattern/key sequences. Every accepted request goes through a local NFA
// predictor and end-of-key requests queue the expected result; a separate
// process compares each accepted result with the oldest one in the queue.
module tb_wildcard_glob_matcher;

  // the spare action code, which the matcher ignores
  localparam logic [1:0] ACT_NONE = 2'd3;
  localparam int IDLE_LIMIT = 500;  // cycles with no handshake on either side
  localparam int REPORT_MAX = 10;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  wgm_pkg::in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  wgm_pkg::out_t out_data;

  // predictor state
  logic [7:0] glob_pattern [wgm_pkg::MAX_PATTERN];
  int glob_len = 0;
  logic glob_overflow = 1'b0;
  logic [wgm_pkg::MAX_PATTERN:0] live_pos = (wgm_pkg::MAX_PATTERN + 1)'(1);

  wgm_pkg::out_t expected_results [$];
  int error_count = 0;
  int requests_sent = 0;  // requests that are not ignored
  int idle_cycles = 0;
  bit steady = 1'b0;      // no idling on either side while set
  int long_hold = 0;      // one-off hold-off picked up by the result sink

  always #5 clk = ~clk;

  wildcard_glob_matcher dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data)
  );

  // ---------------------------------------------------------------------
  // NFA predictor
  // ---------------------------------------------------------------------

  // a live star also makes the position after it live (star matching empty)
  function automatic logic [wgm_pkg::MAX_PATTERN:0] star_closure(
      logic [wgm_pkg::MAX_PATTERN:0] v);
    for (int i = 0; i < glob_len; i++)
      if (v[i] && glob_pattern[i] == wgm_pkg::STAR_BYTE) v[i + 1] = 1'b1;
    return v;
  endfunction

  function automatic void step_glob_nfa(wgm_pkg::in_t r);
    logic [wgm_pkg::MAX_PATTERN:0] nxt;
    wgm_pkg::out_t res;
    nxt = '0;
    case (r.action)
      wgm_pkg::ACT_PATTERN: begin
        if (r.restart) begin
          glob_len = 0;
          glob_overflow = 1'b0;
        end
        if (glob_len < wgm_pkg::MAX_PATTERN) begin
          glob_pattern[glob_len] = r.symbol;
          glob_len++;
        end else begin
          glob_overflow = 1'b1;
        end
        live_pos = star_closure((wgm_pkg::MAX_PATTERN + 1)'(1));
      end
      wgm_pkg::ACT_KEY: begin
        for (int i = 0; i < glob_len; i++) begin
          if (live_pos[i]) begin
            if (glob_pattern[i] == wgm_pkg::STAR_BYTE) nxt[i] = 1'b1;
            else if (glob_pattern[i] == wgm_pkg::ANY_BYTE || glob_pattern[i] == r.symbol)
              nxt[i + 1] = 1'b1;
          end
        end
        live_pos = star_closure(nxt);
      end
      wgm_pkg::ACT_END: begin
        res.matched = live_pos[glob_len] && !glob_overflow;
        res.pattern_too_long = glob_overflow;
        expected_results = {expected_results, res};
        live_pos = star_closure((wgm_pkg::MAX_PATTERN + 1)'(1));
      end
      default: ;  // spare code: nothing changes
    endcase
  endfunction

  // ---------------------------------------------------------------------
  // Request side: one request per call, starting and ending on a falling edge
  // ---------------------------------------------------------------------
  task automatic send_request(input logic [1:0] act, input logic [7:0] sym,
                              input logic rst_flag);
    wgm_pkg::in_t r;
    int gap;
    r.action = act;
    r.symbol = sym;
    r.restart = rst_flag;
    gap = steady ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= r;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    step_glob_nfa(r);
    if (act != ACT_NONE) requests_sent++;
    @(negedge clk);
  endtask

  task automatic load_pattern(string s);
    for (int i = 0; i < s.len(); i++) send_request(wgm_pkg::ACT_PATTERN, s[i], i == 0);
  endtask

  task automatic try_key(string s);
    for (int i = 0; i < s.len(); i++) send_request(wgm_pkg::ACT_KEY, s[i], 1'b0);
    send_request(wgm_pkg::ACT_END, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
  endtask

  // ---------------------------------------------------------------------
  // Result side: random stall per result, plus the one-off long hold-off
  // ---------------------------------------------------------------------
  initial begin : result_sink
    int hold;
    @(negedge clk);
    forever begin
      hold = steady ? 0 : $urandom_range(0, 4);
      if (long_hold > 0) begin
        hold += long_hold;
        long_hold = 0;
      end
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(negedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!(out_valid && !out_stall)) @(posedge clk);
      @(negedge clk);
    end
  end

  function automatic void report_mismatch(string what, int exp_v, int act_v);
    error_count++;
    if (error_count <= REPORT_MAX)
      $display("%0t: %s mismatch: expected %0d, got %0d", $time, what, exp_v, act_v);
  endfunction

  // compare every accepted result with the oldest outstanding expectation
  always @(posedge clk) begin
    wgm_pkg::out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result, matched", -1, int'(out_data.matched));
      end else begin
        want = expected_results.pop_front();
        if (out_data.matched !== want.matched)
          report_mismatch("matched", int'(want.matched), int'(out_data.matched));
        if (out_data.pattern_too_long !== want.pattern_too_long)
          report_mismatch("pattern_too_long", int'(want.pattern_too_long),
                          int'(out_data.pattern_too_long));
      end
    end
  end

  // watchdog: too long with no handshake on either channel
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb_wildcard_glob_matcher NOT OK");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // straight out of reset the pattern is empty: only the empty key matches
  task automatic test_empty_pattern();
    send_request(wgm_pkg::ACT_END, 8'h00, 1'b0);
    send_request(wgm_pkg::ACT_KEY, 8'hFF, 1'b0);
    send_request(wgm_pkg::ACT_END, 8'hFF, 1'b1);
  endtask

  // a pattern of stars alone takes the empty key and any other
  task automatic test_star_only();
    load_pattern("*");
    send_request(wgm_pkg::ACT_END, 8'h00, 1'b0);
    try_key("x");
  endtask

  // zero byte as a literal, '?' against 0xFF
  task automatic test_zero_and_any();
    send_request(wgm_pkg::ACT_PATTERN, 8'h00, 1'b1);
    send_request(wgm_pkg::ACT_PATTERN, wgm_pkg::ANY_BYTE, 1'b0);
    send_request(wgm_pkg::ACT_KEY, 8'h00, 1'b0);
    send_request(wgm_pkg::ACT_KEY, 8'hFF, 1'b0);
    send_request(wgm_pkg::ACT_END, 8'h00, 1'b0);
  endtask

  // appending to the pattern mid-key rearms the key; restart on key
  // requests does nothing
  task automatic test_pattern_change_mid_key();
    send_request(wgm_pkg::ACT_KEY, 8'h00, 1'b1);
    send_request(wgm_pkg::ACT_PATTERN, wgm_pkg::STAR_BYTE, 1'b0);
    send_request(wgm_pkg::ACT_KEY, 8'h00, 1'b0);
    send_request(wgm_pkg::ACT_KEY, 8'h55, 1'b1);
    send_request(wgm_pkg::ACT_END, 8'h00, 1'b0);
  endtask

  // spare action code with every other bit set must leave no trace
  task automatic test_spare_action();
    send_request(ACT_NONE, 8'hFF, 1'b1);
    send_request(wgm_pkg::ACT_KEY, 8'h00, 1'b0);
    send_request(wgm_pkg::ACT_END, 8'h00, 1'b0);
  endtask

  // one byte past a full pattern sets the flag; a restart clears it
  task automatic test_pattern_overflow();
    send_request(wgm_pkg::ACT_PATTERN, wgm_pkg::STAR_BYTE, 1'b1);
    for (int i = 1; i <= wgm_pkg::MAX_PATTERN; i++)
      send_request(wgm_pkg::ACT_PATTERN, wgm_pkg::STAR_BYTE, 1'b0);
    try_key("");
    try_key("ab");
    load_pattern("a");
    try_key("a");
  endtask

  // results held back for a long stretch while end-of-key requests keep
  // coming: the output and skid registers fill and in_stall must rise
  task automatic test_result_backpressure();
    steady = 1'b1;
    long_hold = 60;
    for (int i = 0; i < 12; i++)
      send_request(wgm_pkg::ACT_END, 8'($urandom_range(0, 255)), 1'b0);
    steady = 1'b0;
  endtask

  function automatic logic [7:0] pick_pattern_symbol();
    int r;
    r = $urandom_range(0, 9);
    if (r <= 2) return wgm_pkg::STAR_BYTE;
    if (r <= 4) return wgm_pkg::ANY_BYTE;
    if (r <= 8) return 8'(8'h61 + $urandom_range(0, 1));
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [7:0] pick_key_symbol();
    if ($urandom_range(0, 9) < 8) return 8'(8'h61 + $urandom_range(0, 1));
    return 8'($urandom_range(0, 255));
  endfunction

  // mostly whole sequences: a pattern (fresh or appended to), then a few
  // keys, half of them built to fit the pattern; noise thrown in now and then
  task automatic test_random_traffic(int target);
    int start_count;
    int plen;
    int r;
    bit fresh;
    logic [7:0] key_bytes [$];
    start_count = requests_sent;
    while (requests_sent - start_count < target) begin
      steady = ($urandom_range(0, 7) == 0);
      r = $urandom_range(0, 19);
      if (r < 12) plen = $urandom_range(1, 5);
      else if (r < 17) plen = $urandom_range(6, wgm_pkg::MAX_PATTERN);
      else plen = $urandom_range(wgm_pkg::MAX_PATTERN + 1, wgm_pkg::MAX_PATTERN + 4);
      fresh = ($urandom_range(0, 7) != 0);
      for (int i = 0; i < plen; i++)
        send_request(wgm_pkg::ACT_PATTERN, pick_pattern_symbol(), fresh && i == 0);

      repeat ($urandom_range(1, 4)) begin
        key_bytes.delete();
        if ($urandom_range(0, 1)) begin
          // key that fits the stored pattern
          for (int i = 0; i < glob_len; i++) begin
            if (glob_pattern[i] == wgm_pkg::STAR_BYTE)
              repeat ($urandom_range(0, 2)) key_bytes = {key_bytes, pick_key_symbol()};
            else if (glob_pattern[i] == wgm_pkg::ANY_BYTE)
              key_bytes = {key_bytes, 8'($urandom_range(0, 255))};
            else
              key_bytes = {key_bytes, glob_pattern[i]};
          end
        end else begin
          repeat ($urandom_range(0, 6)) key_bytes = {key_bytes, pick_key_symbol()};
        end
        foreach (key_bytes[k]) begin
          if ($urandom_range(0, 29) == 0)
            send_request(ACT_NONE, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
          if ($urandom_range(0, 39) == 0)
            send_request(wgm_pkg::ACT_PATTERN, pick_pattern_symbol(),
                         1'($urandom_range(0, 1)));
          send_request(wgm_pkg::ACT_KEY, key_bytes[k], 1'($urandom_range(0, 1)));
        end
        send_request(wgm_pkg::ACT_END, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      end
    end
    steady = 1'b0;
  endtask

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_empty_pattern();
    test_star_only();
    test_zero_and_any();
    test_pattern_change_mid_key();
    test_spare_action();
    test_pattern_overflow();
    test_result_backpressure();
    test_random_traffic(670);

    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (error_count == 0) begin
      $display("tb_wildcard_glob_matcher OK");
    end else begin
      $display("tb_wildcard_glob_matcher NOT OK");
    end
    $finish;
  end

endmodule
